[rtl/core/kpd_pkg.sv]
// Shared types and constants for the keypad scan and debounce block.
`timescale 1ns / 1ps

package kpd_pkg;

    // Key matrix geometry and field widths
    localparam int NUM_KEYS = 16;
    localparam int KEY_W    = 4;
    localparam int LINE_W   = 4;
    localparam int THR_W    = 4;

    // Debounce threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 4'd5;

    // Row lines all high: no row is driven low
    localparam logic [LINE_W-1:0] ROWS_IDLE = 4'hF;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;

    // Item kinds
    typedef enum logic
    {
        KIND_SCAN  = 1'b0,
        KIND_FETCH = 1'b1
    } kind_t;

    // One input word
    typedef struct packed
    {
        kind_t             kind;
        logic [LINE_W-1:0] row_lines;
        logic [LINE_W-1:0] col_lines;
    } item_t;

    // Decoded key of one scan sample
    typedef struct packed
    {
        logic             hit;
        logic [KEY_W-1:0] key;
    } decode_t;

    // One result word
    typedef struct packed
    {
        logic             event_valid;
        logic [KEY_W-1:0] key_index;
    } result_t;

endpackage

[rtl/core/kpd_decode.sv]
// Decoder from sampled row and column lines to a single key index.
`timescale 1ns / 1ps

module kpd_decode
(
    input  logic [kpd_pkg::LINE_W-1:0] row_lines,
    input  logic [kpd_pkg::LINE_W-1:0] col_lines,
    output kpd_pkg::decode_t           dec
);
    import kpd_pkg::*;

    logic [1:0] row_base;
    logic [4:0] sum;

    // The lowest low row bit wins; bit0 is row3.
    always_comb
    begin
        if (!row_lines[0])
        begin
            row_base = 2'd3;
        end
        else if (!row_lines[1])
        begin
            row_base = 2'd2;
        end
        else if (!row_lines[2])
        begin
            row_base = 2'd1;
        end
        else
        begin
            row_base = 2'd0;
        end
    end

    // Every low column adds its weight; column 0 adds nothing.
    assign sum = 5'(row_base)
               + (col_lines[1] ? 5'd0 : 5'd4)
               + (col_lines[2] ? 5'd0 : 5'd8)
               + (col_lines[3] ? 5'd0 : 5'd12);

    // No row low or a sum past the last key means no key.
    assign dec.hit = (row_lines != ROWS_IDLE) && !sum[4];
    assign dec.key = sum[KEY_W-1:0];

endmodule

[rtl/core/kpd_debounce.sv]
// Per-key debounce counters, debounced levels and sticky press flags.
`timescale 1ns / 1ps

module kpd_debounce
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  kpd_pkg::kind_t            kind,
    input  kpd_pkg::decode_t          dec,
    input  logic [kpd_pkg::THR_W-1:0] threshold,
    output kpd_pkg::result_t          result
);
    import kpd_pkg::*;

    logic [NUM_KEYS-1:0] level_reg;
    logic [NUM_KEYS-1:0] level_next;
    logic [NUM_KEYS-1:0] flag_reg;
    logic [NUM_KEYS-1:0] flag_next;
    logic [THR_W-1:0]    cnt_reg  [NUM_KEYS];
    logic [THR_W-1:0]    cnt_next [NUM_KEYS];
    logic [THR_W-1:0]    cnt_step [NUM_KEYS];
    logic [NUM_KEYS-1:0] sample;
    logic [THR_W-1:0]    thr_eff;
    logic                found;
    logic [KEY_W-1:0]    found_idx;

    // A zero threshold acts as one.
    assign thr_eff = (threshold == '0) ? THR_W'(1) : threshold;

    // Lowest flagged key.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (flag_reg[k])
            begin
                found     = 1'b1;
                found_idx = KEY_W'(k);
            end
        end
    end

    // Sampled level per key and the counter after this sample.
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            sample[k]   = !(dec.hit && (dec.key == KEY_W'(k)));
            cnt_step[k] = (sample[k] != level_reg[k]) ? cnt_reg[k] + 1'b1 : '0;
        end
    end

    // State update for the word being processed.
    always_comb
    begin
        level_next = level_reg;
        flag_next  = flag_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            if (kind == KIND_SCAN)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (cnt_step[k] == thr_eff)
                    begin
                        cnt_next[k]   = '0;
                        level_next[k] = !level_reg[k];
                        if (level_reg[k])
                        begin
                            flag_next[k] = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next[k] = cnt_step[k];
                    end
                end
            end
            else if (found)
            begin
                flag_next[found_idx] = 1'b0;
            end
        end
    end

    // Only a fetch that finds a flag reports an event.
    assign result.event_valid = (kind == KIND_FETCH) && found;
    assign result.key_index   = ((kind == KIND_FETCH) && found) ? found_idx : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '1;
            flag_reg  <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            level_reg <= level_next;
            flag_reg  <= flag_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A fetch that found a key leaves that key's flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && kind == KIND_FETCH && found) |=> !flag_reg[$past(found_idx)])
        else $error("fetched key flag not cleared");

    // A key that goes to pressed has its flag set in the same update.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((($past(level_reg) & ~level_reg) & ~flag_reg) == '0))
        else $error("press without flag");

    // A fetch never changes a debounced level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && kind == KIND_FETCH) |=> (level_reg == $past(level_reg)))
        else $error("fetch changed a debounced level");

endmodule

[rtl/core/keypad_scan_debounce.sv]
// Top level of the 4x4 keypad scan, debounce and key event block.
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    tuser: kind; tdata: row_lines, col_lines
//  m_*       out  tvalid/tready    tuser: event_valid; tdata: key_index, zero pad
//  apb       in   psel/penable     register 0 debounce_threshold at address 0
//
// One word is accepted per cycle unless the output stalls; its result is registered in the output register.
// The input register feeds the decode and debounce logic, which updates all 16
// key counters at once and loads the output register.
// While the output register is stalled, one more word waits in the input register.
// Reset clears all keys to released, all flags and counters, threshold to 5.
`timescale 1ns / 1ps

module keypad_scan_debounce
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [3:0] row_lines, [7:4] col_lines
    input  logic                           s_tuser,  // [0] kind
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // [3:0] key_index, [7:4] zero
    output logic                           m_tuser,  // [0] event_valid
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kpd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kpd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kpd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import kpd_pkg::*;

    logic             in_valid_reg;
    logic             in_valid_next;
    item_t            in_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_res_reg;
    logic [THR_W-1:0] thr_reg;
    logic             advance;
    logic             s_take;
    logic             cfg_write;
    decode_t          dec;
    result_t          result;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD);
    assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD)
                     ? CFG_DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // Flow control: the input word moves on when the output register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg.kind      <= kind_t'(s_tuser);
            in_item_reg.row_lines <= s_tdata[3:0];
            in_item_reg.col_lines <= s_tdata[7:4];
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    // Key decode of the registered sample
    kpd_decode u_decode
    (
        .row_lines (in_item_reg.row_lines),
        .col_lines (in_item_reg.col_lines),
        .dec       (dec)
    );

    // Debounce state and fetch logic
    kpd_debounce u_debounce
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .kind      (in_item_reg.kind),
        .dec       (dec),
        .threshold (thr_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.key_index};
    assign m_tuser  = out_res_reg.event_valid;

    // The input side stalls only while a word is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A result without an event carries key index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'h00))
        else $error("nonzero key index without event");

    // A stalled result word is never overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

[tb/sv/tb_keypad_scan_debounce.sv]
// Self-checking testbench for the keypad scan and debounce block.
`timescale 1ns / 1ps

module tb_keypad_scan_debounce;

    import kpd_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int NO_KEY         = NUM_KEYS;
    localparam int MAX_GAP        = 5;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};

    // One word waiting to be sent, with the idle cycles that come before it.
    typedef struct
    {
        item_t word;
        int    gap;
    } pending_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;  // [3:0] row_lines, [7:4] col_lines
    logic                  s_tuser  = 1'b0; // [0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [3:0] key_index, [7:4] zero
    logic                  m_tuser;        // [0] event_valid
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted key state and the threshold copy.
    logic [NUM_KEYS-1:0] level_q;
    logic [NUM_KEYS-1:0] flag_q;
    logic [THR_W-1:0]    count_q [NUM_KEYS];
    logic [THR_W-1:0]    thr_q;

    pending_t words_q [$];
    result_t  key_events_q [$];

    pending_t staged_word;
    bit       staged       = 1'b0;
    int       gap_left     = 0;
    item_t    cur_word;
    int       words_sent   = 0;
    bit       tx_calm      = 1'b0;
    bit       rx_calm      = 1'b0;
    int       stall_left   = 0;
    int       hold_left    = 0;
    int       hold_req     = 0;
    int       hold_seen    = 0;
    int       err_count    = 0;
    int       quiet_cycles = 0;

    keypad_scan_debounce u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Decode the sampled lines into a key index, or NO_KEY.
    function automatic int sample_key(logic [LINE_W-1:0] rows, logic [LINE_W-1:0] cols);
        int sum;
        if (rows == ROWS_IDLE)
            return NO_KEY;
        if (!rows[0])
            sum = 3;
        else if (!rows[1])
            sum = 2;
        else if (!rows[2])
            sum = 1;
        else
            sum = 0;
        if (!cols[1])
            sum += 4;
        if (!cols[2])
            sum += 8;
        if (!cols[3])
            sum += 12;
        return (sum >= NUM_KEYS) ? NO_KEY : sum;
    endfunction

    // Advance the predicted key state by one word and return its result.
    function automatic result_t debounce_step(item_t w);
        result_t          res;
        int               key;
        logic [THR_W-1:0] thr;
        logic             sample;
        res = '0;
        if (w.kind == KIND_SCAN)
        begin
            key = sample_key(w.row_lines, w.col_lines);
            thr = (thr_q == '0) ? THR_W'(1) : thr_q;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                sample = (k == key) ? 1'b0 : 1'b1;
                if (sample != level_q[k])
                    count_q[k] = count_q[k] + 1'b1;
                else
                    count_q[k] = '0;
                if (count_q[k] == thr)
                begin
                    count_q[k] = '0;
                    level_q[k] = ~level_q[k];
                    if (!level_q[k])
                        flag_q[k] = 1'b1;
                end
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (flag_q[k] && !res.event_valid)
                begin
                    flag_q[k]       = 1'b0;
                    res.event_valid = 1'b1;
                    res.key_index   = KEY_W'(k);
                end
            end
        end
        return res;
    endfunction

    // Row and column lines that sample as the given key, with random don't-care bits.
    function automatic logic [2*LINE_W-1:0] press_lines(int key);
        logic [LINE_W-1:0] rows;
        logic [LINE_W-1:0] cols;
        rows = LINE_W'($urandom);
        case (key % 4)
            3: rows[0] = 1'b0;
            2: rows[1:0] = 2'b01;
            1: rows[2:0] = 3'b011;
            default: rows = 4'b0111;
        endcase
        cols    = 4'hF;
        cols[0] = 1'($urandom_range(0, 1));
        case (key / 4)
            1: cols[1] = 1'b0;
            2: cols[2] = 1'b0;
            3:
            begin
                if ($urandom_range(0, 1))
                    cols[3] = 1'b0;
                else
                    cols[2:1] = 2'b00;
            end
            default: ;
        endcase
        return {cols, rows};
    endfunction

    task automatic send_word(kind_t kind, logic [LINE_W-1:0] rows, logic [LINE_W-1:0] cols);
        pending_t p;
        p.word.kind      = kind;
        p.word.row_lines = rows;
        p.word.col_lines = cols;
        p.gap            = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        words_q.push_back(p);
        words_sent++;
    endtask

    // Wait until every word is sent and every result has come, then a few cycles more.
    task automatic drain();
        while (words_q.size() != 0 || staged || s_tvalid || key_events_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_threshold(logic [THR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_THRESHOLD;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_q = value;
    endtask

    // Mostly press and release sequences sized around the threshold, plus fetches
    // and noise.
    task automatic random_phase(int n_words);
        int                  stop;
        int                  key;
        int                  len;
        int                  pick;
        int                  thr;
        logic [2*LINE_W-1:0] lines;
        stop = words_sent + n_words;
        thr  = (thr_q == '0) ? 1 : int'(thr_q);
        while (words_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                key = $urandom_range(0, NUM_KEYS - 1);
                len = thr - 2 + int'($urandom_range(0, 4));
                if (len < 1)
                    len = 1;
                repeat (len)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(KIND_SCAN, LINE_W'($urandom), LINE_W'($urandom));
                    else
                    begin
                        lines = press_lines(key);
                        send_word(KIND_SCAN, lines[LINE_W-1:0], lines[2*LINE_W-1:LINE_W]);
                    end
                end
                len = thr - 2 + int'($urandom_range(0, 4));
                if (len < 1)
                    len = 1;
                repeat (len) send_word(KIND_SCAN, ROWS_IDLE, LINE_W'($urandom));
                repeat ($urandom_range(0, 2))
                    send_word(KIND_FETCH, LINE_W'($urandom), LINE_W'($urandom));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(KIND_FETCH, LINE_W'($urandom), LINE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_word(kind_t'($urandom_range(0, 1)), LINE_W'($urandom),
                              LINE_W'($urandom));
            end
        end
    endtask

    // Input driver: takes pending words, waits out each gap, holds valid until accepted.
    always @(posedge clk)
    begin : driver
        logic offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                key_events_q.push_back(debounce_step(cur_word));
                offer = 1'b0;
            end
            if (!offer && !staged && words_q.size() != 0)
            begin
                staged_word = words_q.pop_front();
                gap_left    = staged_word.gap;
                staged      = 1'b1;
            end
            if (!offer && staged)
            begin
                if (gap_left == 0)
                begin
                    cur_word = staged_word.word;
                    s_tuser <= cur_word.kind;
                    s_tdata <= {cur_word.col_lines, cur_word.row_lines};
                    offer    = 1'b1;
                    staged   = 1'b0;
                end
                else
                begin
                    gap_left--;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Result monitor: checks each word against the oldest prediction and paces tready.
    always @(posedge clk)
    begin : monitor
        result_t want;
        logic    rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (key_events_q.size() == 0)
                begin
                    $error("unexpected result word: event_valid %0d, key_index %0d",
                           m_tuser, m_tdata[KEY_W-1:0]);
                    err_count++;
                end
                else
                begin
                    want = key_events_q.pop_front();
                    if (m_tuser !== want.event_valid)
                    begin
                        $error("event_valid: expected %0d, actual %0d",
                               want.event_valid, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[KEY_W-1:0] !== want.key_index)
                    begin
                        $error("key_index: expected %0d, actual %0d",
                               want.key_index, m_tdata[KEY_W-1:0]);
                        err_count++;
                    end
                    if (m_tdata[7:KEY_W] !== '0)
                    begin
                        $error("tdata pad: expected 0, actual %0h", m_tdata[7:KEY_W]);
                        err_count++;
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            // A requested long hold takes precedence over the per-word stall.
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // Count cycles with work outstanding but no word moving on either side.
    always @(posedge clk)
    begin : quiet_count
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            !(words_q.size() != 0 || staged || s_tvalid || key_events_q.size() != 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb_keypad_scan_debounce: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        // Predicted state after reset: all released, no flags, threshold 5.
        level_q = '1;
        flag_q  = '0;
        thr_q   = THR_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
            count_q[k] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: hold key 15 long enough to flag it, then fetch twice.
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (5) send_word(KIND_SCAN, 4'hE, 4'h7);
        send_word(KIND_FETCH, 4'h0, 4'h0);
        send_word(KIND_FETCH, 4'hF, 4'hF);
        drain();

        // Threshold 1: every differing sample toggles, so each decode case shows at once.
        write_threshold(THR_W'(1));
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_word(KIND_FETCH, 4'h0, 4'h0); // nothing flagged, lines ignored
        send_word(KIND_SCAN, 4'hF, 4'h0);  // no row low
        send_word(KIND_SCAN, 4'h0, 4'hF);  // several rows low, no column low
        send_word(KIND_SCAN, 4'hE, 4'hF);  // same key held
        send_word(KIND_SCAN, 4'h7, 4'hE);  // top row only, zero-weight column
        send_word(KIND_SCAN, 4'h0, 4'h0);  // column sum too large
        send_word(KIND_SCAN, 4'hB, 4'h9);  // two columns add up
        send_word(KIND_SCAN, 4'hD, 4'h7);  // heaviest column
        send_word(KIND_SCAN, 4'hE, 4'h5);  // sum past the key range
        send_word(KIND_SCAN, 4'hF, 4'hF);  // all lines idle
        send_word(KIND_FETCH, 4'hF, 4'hF);
        send_word(KIND_FETCH, 4'h0, 4'h0);
        send_word(KIND_FETCH, 4'h5, 4'hA);
        send_word(KIND_FETCH, 4'hA, 4'h5);
        send_word(KIND_FETCH, 4'hF, 4'hF); // flags exhausted
        drain();

        // A zero threshold behaves as one.
        write_threshold('0);
        random_phase(200);
        drain();

        write_threshold(THR_W'(15));
        random_phase(400);
        drain();

        // Receiver holds off for a long stretch while words arrive back to back.
        write_threshold(THR_W'($urandom_range(2, 14)));
        tx_calm = 1'b1;
        hold_req++;
        random_phase(60);
        drain();
        tx_calm = 1'b0;

        // No idling on either side.
        write_threshold(THR_RESET);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        random_phase(400);
        drain();
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        write_threshold(THR_W'($urandom_range(1, 15)));
        random_phase(500);
        drain();

        write_threshold(THR_W'(1));
        random_phase(300);
        drain();

        write_threshold(THR_W'(3));
        random_phase(200);
        drain();

        if (err_count == 0)
            $display("tb_keypad_scan_debounce: PASS");
        else
            $display("tb_keypad_scan_debounce: FAIL");
        $finish;
    end

endmodule
